// File: rtl/led_ring_clock_keeper_top_assert.svh
// Assertion macros shared by the clock keeper modules.
// Each use expects clk and rst_n in the including module's scope.
`ifndef LED_RING_CLOCK_KEEPER_TOP_ASSERT_SVH
`define LED_RING_CLOCK_KEEPER_TOP_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define LRCK_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence must hold in the same cycle as the antecedent.
`define LRCK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define LRCK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lrck_pkg.sv
// Types and constants shared by the LED ring clock keeper.
// No dependencies.
package lrck_pkg;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_BYTE   = 2'd1,
        MODE_RENDER = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SEC_RED   = 3'd0,
        REG_MIN_BLUE  = 3'd1,
        REG_HOUR_GRN  = 3'd2,
        REG_BLINK     = 3'd3,
        REG_MARKER    = 3'd4
    } reg_index_t;

    localparam int unsigned RING_SIZE   = 60;
    localparam logic [5:0]  LED_LAST    = 6'd59;
    localparam logic [5:0]  SEC_LAST    = 6'd59;
    localparam logic [5:0]  MIN_LAST    = 6'd59;
    localparam logic [4:0]  HOUR_LAST   = 5'd23;
    localparam int unsigned LINE_KEEP   = 6;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_CR   = 8'd13;
    localparam logic [7:0] ASCII_LF   = 8'd10;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_NINE = 8'd57;

    localparam logic [7:0] RESET_RED   = 8'd3;
    localparam logic [7:0] RESET_BLUE  = 8'd3;
    localparam logic [7:0] RESET_GREEN = 8'd2;
    localparam logic       RESET_BLINK  = 1'b1;
    localparam logic       RESET_MARKER = 1'b1;

    // Time captured for one render request
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [5:0] hour_pos;
    } snap_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] blue;
        logic [7:0] green;
        logic       blink;
        logic       marker;
    } cfg_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

    // Two ASCII digits to a value 0..99; only the low nibbles matter
    function automatic logic [6:0] two_digit(input logic [7:0] hi, input logic [7:0] lo);
        return {hi[3:0], 3'b000} + {2'b00, hi[3:0], 1'b0} + {3'b000, lo[3:0]};
    endfunction

endpackage

// File: rtl/lrck_queue.sv
// Short queue of render snapshots between front and render stage.
// Depends on lrck_pkg.
module lrck_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lrck_pkg::snap_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output lrck_pkg::snap_t head
);

    localparam int unsigned DEPTH = lrck_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lrck_pkg::snap_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/lrck_front.sv
// Front end: accepts words, keeps the time, parses serial lines, queues renders.
// Depends on lrck_pkg and the assertion macro header.
`include "led_ring_clock_keeper_top_assert.svh"

module lrck_front
#(
    parameter int unsigned LINE_DEPTH = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_mode,
    input  logic [7:0]      in_byte,
    output logic            push,
    output lrck_pkg::snap_t push_data,
    input  logic            queue_full
);

    localparam logic [4:0] LEN_MAX  = 5'(LINE_DEPTH);
    localparam logic [4:0] LEN_KEEP = 5'(lrck_pkg::LINE_KEEP);

    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic [4:0] line_len_reg, line_len_next;
    logic [7:0] line_digits_reg [lrck_pkg::LINE_KEEP];

    lrck_pkg::mode_t mode;
    logic accept, is_term, store_byte;
    logic digits_ok, line_ok;
    logic [6:0] sec_val, min_val, hour_val;
    logic [6:0] hour_x5;
    logic [11:0] min_x43;
    logic [6:0] pos_sum;

    assign mode     = lrck_pkg::mode_t'(in_mode);
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (mode == lrck_pkg::MODE_RENDER);
    assign is_term  = (in_byte == lrck_pkg::ASCII_CR) || (in_byte == lrck_pkg::ASCII_LF);
    assign store_byte = accept && (mode == lrck_pkg::MODE_BYTE) && !is_term
                        && (line_len_reg < LEN_KEEP);

    // Hour hand position: (5*h + m/12) mod 60, m/12 as (m*43) >> 9
    assign hour_x5 = {hour_reg, 2'b00} + {2'b00, hour_reg};
    assign min_x43 = min_reg * 6'd43;
    assign pos_sum = hour_x5 + {4'b0000, min_x43[11:9]};

    always_comb
    begin
        push_data.sec = sec_reg;
        push_data.min = min_reg;
        push_data.hour_pos = (pos_sum >= 7'd60) ? 6'(pos_sum - 7'd60) : pos_sum[5:0];
    end

    always_comb
    begin
        digits_ok = 1'b1;
        for (int i = 0; i < lrck_pkg::LINE_KEEP; i++)
        begin
            digits_ok = digits_ok && lrck_pkg::is_digit(line_digits_reg[i]);
        end
        sec_val  = lrck_pkg::two_digit(line_digits_reg[0], line_digits_reg[1]);
        min_val  = lrck_pkg::two_digit(line_digits_reg[2], line_digits_reg[3]);
        hour_val = lrck_pkg::two_digit(line_digits_reg[4], line_digits_reg[5]);
        line_ok  = (line_len_reg == LEN_KEEP) && digits_ok
                   && (sec_val < 7'd60) && (min_val < 7'd60) && (hour_val < 7'd24);
    end

    always_comb
    begin
        sec_next      = sec_reg;
        min_next      = min_reg;
        hour_next     = hour_reg;
        line_len_next = line_len_reg;
        if (accept)
        begin
            case (mode)
                lrck_pkg::MODE_TICK:
                begin
                    if (sec_reg == lrck_pkg::SEC_LAST)
                    begin
                        sec_next = '0;
                        if (min_reg == lrck_pkg::MIN_LAST)
                        begin
                            min_next  = '0;
                            hour_next = (hour_reg == lrck_pkg::HOUR_LAST) ? '0
                                                                           : hour_reg + 1'b1;
                        end
                        else
                        begin
                            min_next = min_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sec_next = sec_reg + 1'b1;
                    end
                end
                lrck_pkg::MODE_BYTE:
                begin
                    if (is_term)
                    begin
                        line_len_next = '0;
                        if (line_ok)
                        begin
                            sec_next  = sec_val[5:0];
                            min_next  = min_val[5:0];
                            hour_next = hour_val[4:0];
                        end
                    end
                    else if (line_len_reg < LEN_MAX)
                    begin
                        line_len_next = line_len_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg      <= '0;
            min_reg      <= '0;
            hour_reg     <= '0;
            line_len_reg <= '0;
        end
        else
        begin
            sec_reg      <= sec_next;
            min_reg      <= min_next;
            hour_reg     <= hour_next;
            line_len_reg <= line_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_byte)
        begin
            line_digits_reg[line_len_reg[2:0]] <= in_byte;
        end
    end

    `LRCK_ASSERT_ALWAYS(a_line_len_sat, line_len_reg <= LEN_MAX, "line length past saturation")
    `LRCK_ASSERT_ALWAYS(a_time_range,
        (sec_reg <= lrck_pkg::SEC_LAST) && (min_reg <= lrck_pkg::MIN_LAST)
        && (hour_reg <= lrck_pkg::HOUR_LAST), "time out of range")
    `LRCK_ASSERT_NEXT(a_term_clears,
        accept && (mode == lrck_pkg::MODE_BYTE) && is_term, line_len_reg == '0,
        "line not cleared after terminator")

endmodule

// File: rtl/lrck_render.sv
// Render stage: walks one queued snapshot over the 60 LEDs, one word a cycle unless the output stalls.
// Depends on lrck_pkg and the assertion macro header.
`include "led_ring_clock_keeper_top_assert.svh"

module lrck_render
(
    input  logic            clk,
    input  logic            rst_n,
    input  lrck_pkg::cfg_t  cfg,
    input  logic            snap_valid,
    input  lrck_pkg::snap_t snap,
    output logic            snap_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [5:0]      out_index,
    output logic [7:0]      out_green,
    output logic [7:0]      out_red,
    output logic [7:0]      out_blue,
    output logic            out_last
);

    logic [5:0] led_cnt_reg, led_cnt_next;
    logic       valid_reg, valid_next;
    logic [5:0] index_reg;
    logic [7:0] green_reg, red_reg, blue_reg;
    logic       last_reg;

    logic load, at_last;
    logic hit_sec, hit_min, hit_hour, marker_on;
    logic [7:0] red_c, green_c, blue_c;

    assign load     = snap_valid && (!valid_reg || out_ready);
    assign at_last  = (led_cnt_reg == lrck_pkg::LED_LAST);
    assign snap_pop = load && at_last;

    always_comb
    begin
        hit_sec  = (led_cnt_reg == snap.sec);
        hit_min  = (led_cnt_reg == snap.min) && (!cfg.blink || snap.sec[0]);
        hit_hour = (led_cnt_reg == snap.hour_pos);
        red_c    = hit_sec  ? cfg.red   : 8'd0;
        blue_c   = hit_min  ? cfg.blue  : 8'd0;
        green_c  = hit_hour ? cfg.green : 8'd0;
        // Light a dark LED 0 with all three levels as the twelve o'clock mark
        marker_on = cfg.marker && (led_cnt_reg == '0)
                    && (red_c == 8'd0) && (green_c == 8'd0) && (blue_c == 8'd0);
        if (marker_on)
        begin
            red_c   = cfg.red;
            green_c = cfg.green;
            blue_c  = cfg.blue;
        end
    end

    always_comb
    begin
        led_cnt_next = led_cnt_reg;
        valid_next   = valid_reg;
        if (load)
        begin
            led_cnt_next = at_last ? '0 : led_cnt_reg + 1'b1;
            valid_next   = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            led_cnt_reg <= led_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= led_cnt_reg;
            green_reg <= green_c;
            red_reg   <= red_c;
            blue_reg  <= blue_c;
            last_reg  <= at_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_green = green_reg;
    assign out_red   = red_reg;
    assign out_blue  = blue_reg;
    assign out_last  = last_reg;

    `LRCK_ASSERT_ALWAYS(a_cnt_range, led_cnt_reg <= lrck_pkg::LED_LAST, "LED counter past ring")
    `LRCK_ASSERT_SAME(a_last_index, valid_reg && last_reg,
        index_reg == lrck_pkg::LED_LAST, "frame end on wrong LED")
    `LRCK_ASSERT_NEXT(a_frame_contiguous, valid_reg && out_ready && !last_reg, valid_reg,
        "gap inside a frame")

endmodule

// File: rtl/led_ring_clock_keeper_top.sv
// LED ring clock keeper, top level: configuration registers, front end, queue, render.
// Ticks and serial bytes take effect at the accepting edge and give no output.
// A render request yields 60 words, the first registered through the queue and the output
// register, then one a cycle while m_tready is high; the render counter sets the rate.
// Asynchronous active-low reset returns the time to 0:0:0 and the levels to defaults.
module led_ring_clock_keeper_top
#(
    parameter int unsigned LINE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [5:0] led_index, [13:6] green, [21:14] red,
                                   // [29:22] blue, [31:30] zero
    output logic        m_tlast,   // last_led
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    lrck_pkg::cfg_t cfg_reg;
    lrck_pkg::snap_t push_data, head;
    logic push, queue_full, not_empty, pop;
    logic [5:0] led_index;
    logic [7:0] green, red, blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red    <= lrck_pkg::RESET_RED;
            cfg_reg.blue   <= lrck_pkg::RESET_BLUE;
            cfg_reg.green  <= lrck_pkg::RESET_GREEN;
            cfg_reg.blink  <= lrck_pkg::RESET_BLINK;
            cfg_reg.marker <= lrck_pkg::RESET_MARKER;
        end
        else if (cfg_we)
        begin
            case (lrck_pkg::reg_index_t'(cfg_index))
                lrck_pkg::REG_SEC_RED:  cfg_reg.red    <= cfg_data;
                lrck_pkg::REG_MIN_BLUE: cfg_reg.blue   <= cfg_data;
                lrck_pkg::REG_HOUR_GRN: cfg_reg.green  <= cfg_data;
                lrck_pkg::REG_BLINK:    cfg_reg.blink  <= cfg_data[0];
                lrck_pkg::REG_MARKER:   cfg_reg.marker <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    lrck_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_byte    (s_tdata),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    lrck_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    lrck_render u_render (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .snap_valid (not_empty),
        .snap       (head),
        .snap_pop   (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (led_index),
        .out_green  (green),
        .out_red    (red),
        .out_blue   (blue),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, blue, red, green, led_index};

endmodule

// File: dv/tb_led_ring_clock_keeper_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_ring_clock_keeper_top; uses lrck_pkg and the top-level RTL.
// Drives ticks, serial lines and render requests on the input stream, predicts every LED
// word of each frame and checks it on the output stream under several register settings.
module tb_led_ring_clock_keeper_top;

    localparam int unsigned LINE_DEPTH     = 16;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PHASE_WORDS    = 30;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned DIRECTED_ROWS  = 25;

    // Output word as it appears on {m_tlast, m_tdata}
    typedef struct packed {
        logic       last_led;
        logic [1:0] pad;
        logic [7:0] blue;
        logic [7:0] red;
        logic [7:0] green;
        logic [5:0] led_index;
    } led_word_t;

    // One directed input word; pinned rows carry the time the frame must show
    typedef struct packed {
        lrck_pkg::mode_t mode;
        logic [7:0]      data;
        logic            pinned;
        logic [5:0]      ss;
        logic [5:0]      mm;
        logic [4:0]      hh;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Clock state and settings as the block should hold them
    logic [5:0]  clk_sec;
    logic [5:0]  clk_min;
    logic [4:0]  clk_hour;
    logic [7:0]  line_buf [lrck_pkg::LINE_KEEP];
    logic [4:0]  line_len;
    logic [7:0]  lvl_red;
    logic [7:0]  lvl_blue;
    logic [7:0]  lvl_green;
    logic        blink_on;
    logic        marker_on;

    led_word_t   expected_leds [$];
    int unsigned mismatches    = 0;
    int unsigned words_offered = 0;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_stall_pct  = 0;
    bit          rx_hold_req   = 1'b0;
    bit          pin_active    = 1'b0;
    logic [5:0]  pin_sec;
    logic [5:0]  pin_min;
    logic [4:0]  pin_hour;

    step_row_t directed_steps [DIRECTED_ROWS] = '{
        '{lrck_pkg::MODE_RENDER, 8'h00,                       1'b1, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_TICK,   8'h00,                       1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_RENDER, 8'hFF,                       1'b1, 6'd1,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO + 8'd5, 1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO + 8'd9, 1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO + 8'd5, 1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO + 8'd9, 1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO + 8'd2, 1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO + 8'd3, 1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_LF,          1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_RENDER, 8'h00,                       1'b1, 6'd59, 6'd59, 5'd23},
        '{lrck_pkg::MODE_TICK,   8'hFF,                       1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_RENDER, 8'h00,                       1'b1, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_NONE,   8'hFF,                       1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   8'hFF,                       1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   8'h00,                       1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_CR,          1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO + 8'd6, 1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO,        1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO,        1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO,        1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO,        1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_ZERO,        1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_BYTE,   lrck_pkg::ASCII_CR,          1'b0, 6'd0,  6'd0,  5'd0},
        '{lrck_pkg::MODE_RENDER, 8'h00,                       1'b1, 6'd0,  6'd0,  5'd0}
    };

    led_ring_clock_keeper_top #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Update the clock for one accepted input word; a render queues its 60 LED words
    function automatic void predict_word(input lrck_pkg::mode_t mode, input logic [7:0] data);
        logic [7:0]  grn [lrck_pkg::RING_SIZE];
        logic [7:0]  red [lrck_pkg::RING_SIZE];
        logic [7:0]  blu [lrck_pkg::RING_SIZE];
        logic [5:0]  ss;
        logic [5:0]  mm;
        logic [4:0]  hh;
        int unsigned vals [3];
        int unsigned hour_pos;
        bit          line_ok;
        led_word_t   w;
        case (mode)
            lrck_pkg::MODE_TICK:
            begin
                if (clk_sec == lrck_pkg::SEC_LAST)
                begin
                    clk_sec = '0;
                    if (clk_min == lrck_pkg::MIN_LAST)
                    begin
                        clk_min  = '0;
                        clk_hour = (clk_hour == lrck_pkg::HOUR_LAST) ? 5'd0 : clk_hour + 5'd1;
                    end
                    else
                        clk_min = clk_min + 6'd1;
                end
                else
                    clk_sec = clk_sec + 6'd1;
            end
            lrck_pkg::MODE_BYTE:
            begin
                if (data == lrck_pkg::ASCII_CR || data == lrck_pkg::ASCII_LF)
                begin
                    // only six in-range digits, read as ssmmhh, set the time
                    line_ok = (line_len == lrck_pkg::LINE_KEEP);
                    for (int i = 0; i < lrck_pkg::LINE_KEEP; i++)
                        if (line_ok && (line_buf[i] < lrck_pkg::ASCII_ZERO
                                        || line_buf[i] > lrck_pkg::ASCII_NINE))
                            line_ok = 1'b0;
                    if (line_ok)
                    begin
                        for (int i = 0; i < 3; i++)
                            vals[i] = 10 * (line_buf[2 * i] - lrck_pkg::ASCII_ZERO)
                                    + (line_buf[2 * i + 1] - lrck_pkg::ASCII_ZERO);
                        if (vals[0] <= lrck_pkg::SEC_LAST && vals[1] <= lrck_pkg::MIN_LAST
                            && vals[2] <= lrck_pkg::HOUR_LAST)
                        begin
                            clk_sec  = 6'(vals[0]);
                            clk_min  = 6'(vals[1]);
                            clk_hour = 5'(vals[2]);
                        end
                    end
                    line_len = '0;
                end
                else
                begin
                    if (line_len < lrck_pkg::LINE_KEEP)
                        line_buf[line_len] = data;
                    if (line_len < LINE_DEPTH)
                        line_len = line_len + 5'd1;
                end
            end
            lrck_pkg::MODE_RENDER:
            begin
                ss = pin_active ? pin_sec : clk_sec;
                mm = pin_active ? pin_min : clk_min;
                hh = pin_active ? pin_hour : clk_hour;
                for (int i = 0; i < lrck_pkg::RING_SIZE; i++)
                begin
                    grn[i] = '0;
                    red[i] = '0;
                    blu[i] = '0;
                end
                red[ss] = lvl_red;
                if (!blink_on || ss[0])
                    blu[mm] = lvl_blue;
                hour_pos = (5 * hh + mm / 12) % lrck_pkg::RING_SIZE;
                grn[hour_pos] = lvl_green;
                // twelve o'clock mark only on a fully dark LED 0
                if (marker_on && red[0] == 8'd0 && grn[0] == 8'd0 && blu[0] == 8'd0)
                begin
                    red[0] = lvl_red;
                    grn[0] = lvl_green;
                    blu[0] = lvl_blue;
                end
                for (int i = 0; i < lrck_pkg::RING_SIZE; i++)
                begin
                    w.last_led  = (i == lrck_pkg::RING_SIZE - 1);
                    w.pad       = 2'b00;
                    w.blue      = blu[i];
                    w.red       = red[i];
                    w.green     = grn[i];
                    w.led_index = 6'(i);
                    expected_leds.push_back(w);
                end
            end
            default: ;
        endcase
    endfunction

    // Check output words first; an input accepted at this edge cannot have produced one yet
    always @(posedge clk)
    begin
        led_word_t got;
        led_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tlast, m_tdata};
            if (expected_leds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected LED word: index %0d g %0d r %0d b %0d last %0b",
                             got.led_index, got.green, got.red, got.blue, got.last_led);
            end
            else
            begin
                want = expected_leds.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("LED word mismatch: expected index %0d g %0d r %0d b %0d %s",
                                 want.led_index, want.green, want.red, want.blue, "");
                        $display("  expected last %0b pad %0d", want.last_led, want.pad);
                        $display("  got index %0d g %0d r %0d b %0d last %0b pad %0d",
                                 got.led_index, got.green, got.red, got.blue,
                                 got.last_led, got.pad);
                    end
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            predict_word(lrck_pkg::mode_t'(s_tuser), s_tdata);
    end

    // Receiver: random stalls, or one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
        $display("tb_led_ring_clock_keeper_top failed");
        $finish;
    end

    // Offer one word, idling first at random; returns on the falling edge after acceptance
    task automatic send_word(input lrck_pkg::mode_t mode, input logic [7:0] data);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        if (mode != lrck_pkg::MODE_NONE)
            words_offered++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_terminator();
        return $urandom_range(1) ? lrck_pkg::ASCII_CR : lrck_pkg::ASCII_LF;
    endfunction

    function automatic logic [7:0] pick_digit();
        return lrck_pkg::ASCII_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic send_line(input int unsigned ss, input int unsigned mm, input int unsigned hh);
        send_word(lrck_pkg::MODE_BYTE, lrck_pkg::ASCII_ZERO + 8'(ss / 10));
        send_word(lrck_pkg::MODE_BYTE, lrck_pkg::ASCII_ZERO + 8'(ss % 10));
        send_word(lrck_pkg::MODE_BYTE, lrck_pkg::ASCII_ZERO + 8'(mm / 10));
        send_word(lrck_pkg::MODE_BYTE, lrck_pkg::ASCII_ZERO + 8'(mm % 10));
        send_word(lrck_pkg::MODE_BYTE, lrck_pkg::ASCII_ZERO + 8'(hh / 10));
        send_word(lrck_pkg::MODE_BYTE, lrck_pkg::ASCII_ZERO + 8'(hh % 10));
        send_word(lrck_pkg::MODE_BYTE, pick_terminator());
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned ss;
        int unsigned mm;
        int unsigned hh;
        int unsigned len;
        int unsigned bad_pos;
        stop_at = words_offered + target;
        while (words_offered < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                send_word(lrck_pkg::MODE_RENDER, 8'($urandom));
            else if (pick < 40)
                repeat ($urandom_range(3, 1)) send_word(lrck_pkg::MODE_TICK, 8'($urandom));
            else if (pick < 65)
            begin
                // valid time, often right at a carry so the following ticks roll it over
                if ($urandom_range(3) == 0)
                begin
                    ss = 59;
                    mm = 59;
                    hh = 23;
                end
                else
                begin
                    ss = ($urandom_range(2) == 0) ? 59 : $urandom_range(59);
                    mm = ($urandom_range(2) == 0) ? 59 : $urandom_range(59);
                    hh = $urandom_range(23);
                end
                send_line(ss, mm, hh);
            end
            else if (pick < 85)
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        // one field out of range
                        ss = $urandom_range(59);
                        mm = $urandom_range(59);
                        hh = $urandom_range(23);
                        case ($urandom_range(2))
                            0: ss = $urandom_range(99, 60);
                            1: mm = $urandom_range(99, 60);
                            default: hh = $urandom_range(99, 24);
                        endcase
                        send_line(ss, mm, hh);
                    end
                    1:
                    begin
                        // wrong length, including past the saturation point
                        len = $urandom_range(20);
                        repeat (len) send_word(lrck_pkg::MODE_BYTE, pick_digit());
                        send_word(lrck_pkg::MODE_BYTE, pick_terminator());
                    end
                    default:
                    begin
                        bad_pos = $urandom_range(lrck_pkg::LINE_KEEP - 1);
                        for (int i = 0; i < lrck_pkg::LINE_KEEP; i++)
                            send_word(lrck_pkg::MODE_BYTE,
                                      (i == bad_pos) ? 8'($urandom) : pick_digit());
                        send_word(lrck_pkg::MODE_BYTE, pick_terminator());
                    end
                endcase
            end
            else if (pick < 93)
                send_word(lrck_pkg::MODE_BYTE, 8'($urandom));
            else
                send_word(lrck_pkg::MODE_NONE, 8'($urandom));
        end
    endtask

    task automatic write_reg(input lrck_pkg::reg_index_t idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            lrck_pkg::REG_SEC_RED:  lvl_red   = val;
            lrck_pkg::REG_MIN_BLUE: lvl_blue  = val;
            lrck_pkg::REG_HOUR_GRN: lvl_green = val;
            lrck_pkg::REG_BLINK:    blink_on  = val[0];
            lrck_pkg::REG_MARKER:   marker_on = val[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Flag registers get random upper bits; only bit 0 counts
    task automatic apply_settings(input logic [7:0] red, input logic [7:0] blue,
                                  input logic [7:0] green, input logic blink,
                                  input logic marker);
        write_reg(lrck_pkg::REG_SEC_RED, red);
        write_reg(lrck_pkg::REG_MIN_BLUE, blue);
        write_reg(lrck_pkg::REG_HOUR_GRN, green);
        write_reg(lrck_pkg::REG_BLINK, {7'($urandom), blink});
        write_reg(lrck_pkg::REG_MARKER, {7'($urandom), marker});
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_leds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = lrck_pkg::MODE_TICK;
        cfg_we    = 1'b0;
        cfg_index = lrck_pkg::REG_SEC_RED;
        cfg_data  = '0;
        clk_sec   = '0;
        clk_min   = '0;
        clk_hour  = '0;
        line_len  = '0;
        lvl_red   = lrck_pkg::RESET_RED;
        lvl_blue  = lrck_pkg::RESET_BLUE;
        lvl_green = lrck_pkg::RESET_GREEN;
        blink_on  = lrck_pkg::RESET_BLINK;
        marker_on = lrck_pkg::RESET_MARKER;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_steps[i])
        begin
            pin_active = directed_steps[i].pinned;
            pin_sec    = directed_steps[i].ss;
            pin_min    = directed_steps[i].mm;
            pin_hour   = directed_steps[i].hh;
            send_word(directed_steps[i].mode, directed_steps[i].data);
        end
        pin_active = 1'b0;

        wait_drained();
        apply_settings(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
        run_random(PHASE_WORDS);

        wait_drained();
        apply_settings(8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
        tx_idle_pct = 56;
        run_random(PHASE_WORDS);

        // hold the output long enough for renders to back up into the input
        wait_drained();
        apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0);
        tx_idle_pct  = 0;
        rx_stall_pct = 56;
        rx_hold_req  = 1'b1;
        repeat (5) send_word(lrck_pkg::MODE_RENDER, 8'($urandom));
        run_random(PHASE_WORDS);

        wait_drained();
        apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b1);
        tx_idle_pct  = 13;
        rx_stall_pct = 13;
        run_random(PHASE_WORDS);

        wait_drained();
        if (mismatches == 0 && expected_leds.size() == 0)
            $display("tb_led_ring_clock_keeper_top passed");
        else
            $display("tb_led_ring_clock_keeper_top failed");
        $finish;
    end

endmodule

// File: led_ring_clock_keeper_top.f
+incdir+rtl
rtl/lrck_pkg.sv
rtl/lrck_queue.sv
rtl/lrck_front.sv
rtl/lrck_render.sv
rtl/led_ring_clock_keeper_top.sv
dv/tb_led_ring_clock_keeper_top.sv
